FILE: rtl/core/tsab_pkg.sv
// Package for the timestamp-aligned sample buffer: field widths, opcodes,
// reset constants and the wrapped-time comparison. No dependencies.
package tsab_pkg;

    localparam int TIME_W = 32;
    localparam int PER_W  = 31;
    localparam int OFF_W  = 10;
    localparam int BYTE_W = 8;
    localparam int HELD_W = 5;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_PULL = 1'b1;

    localparam logic [PER_W-1:0] PER_RESET = 31'd78643200;

    // True when time a lies before time b within a window of half a period.
    function automatic logic time_before(input logic [TIME_W-1:0] a,
                                         input logic [TIME_W-1:0] b,
                                         input logic [TIME_W-1:0] half);
        logic r;
        if (a == b) begin
            r = 1'b0;
        end else if (a < b) begin
            r = ((b - a) <= half);
        end else begin
            r = ((a - b) > half);
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/tsab_intf.sv
// Request and response channel interfaces of the sample buffer.
// Depends on tsab_pkg for the field widths.
interface tsab_req_if import tsab_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              opcode;
    logic [TIME_W-1:0] packet_time;
    logic [OFF_W-1:0]  sample_offset;
    logic [BYTE_W-1:0] i_in;
    logic [BYTE_W-1:0] q_in;
    logic [TIME_W-1:0] pull_time;

    modport src (output valid, opcode, packet_time, sample_offset, i_in, q_in, pull_time,
                 input ready);
    modport snk (input valid, opcode, packet_time, sample_offset, i_in, q_in, pull_time,
                 output ready);
endinterface

interface tsab_rsp_if import tsab_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] i_out;
    logic [BYTE_W-1:0] q_out;
    logic              sample_missing;
    logic              push_dropped;
    logic [HELD_W-1:0] packets_held;

    modport src (output valid, i_out, q_out, sample_missing, push_dropped, packets_held,
                 input ready);
    modport snk (input valid, i_out, q_out, sample_missing, push_dropped, packets_held,
                 output ready);
endinterface

FILE: rtl/core/tsab_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module tsab_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/tsab_div.sv
// Bit-serial remainder unit: dividend modulo divisor, one quotient bit per cycle.
// Depends on tsab_pkg for widths.
module tsab_div import tsab_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [TIME_W-1:0] i_dividend,
    input  logic [PER_W-1:0]  i_divisor,
    output logic              o_done,
    output logic [PER_W-1:0]  o_rem
);

    localparam int CNT_W = $clog2(TIME_W);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [TIME_W-1:0] r_x, n_x;
    logic [PER_W-1:0]  r_rem, n_rem;

    logic [TIME_W-1:0] div_ext;
    logic [TIME_W-1:0] shifted;

    assign div_ext = {1'b0, i_divisor};
    assign shifted = {r_rem, r_x[TIME_W-1]};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_x    = r_x;
        n_rem  = r_rem;
        if (r_busy) begin
            if (shifted >= div_ext) begin
                n_rem = PER_W'(shifted - div_ext);
            end else begin
                n_rem = shifted[PER_W-1:0];
            end
            n_x   = {r_x[TIME_W-2:0], 1'b0};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end else if (i_start) begin
            // A dividend already below the divisor is its own remainder.
            if (i_dividend < div_ext) begin
                n_rem  = i_dividend[PER_W-1:0];
                n_done = 1'b1;
            end else begin
                n_x    = i_dividend;
                n_rem  = '0;
                n_cnt  = CNT_W'(TIME_W - 1);
                n_busy = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_x   <= n_x;
        r_rem <= n_rem;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

FILE: rtl/core/timestamp_aligned_sample_buffer.sv
// Timestamp-aligned sample buffer, top level. Uses tsab_pkg, tsab_intf, tsab_ram, tsab_div.
// A push writes its sample in the accept cycle; the last sample of a packet also waits for the
// modulo unit. A pull runs its time through the modulo unit and drops stale head packets one by
// one, and a stale start time adds another modulo pass. One transaction is in work at a time; a
// finished result waits in the output register. Reset (synchronous, active low) empties the
// ring, period 78643200.
module timestamp_aligned_sample_buffer import tsab_pkg::*; #(
    parameter int SLOT_COUNT       = 16,
    parameter int SAMPLES_PER_SLOT = 640
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [PER_W-1:0] i_cfg_wdata,
    tsab_req_if.snk          i_req,
    tsab_rsp_if.src          o_rsp
);

    localparam int SW    = $clog2(SLOT_COUNT);
    localparam int CW    = $clog2(SLOT_COUNT + 1);
    localparam int DEPTH = SLOT_COUNT * SAMPLES_PER_SLOT;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [TIME_W-1:0] SPS_T   = TIME_W'(SAMPLES_PER_SLOT);
    localparam logic [PER_W-1:0]  MIN_PER = PER_W'(2 * SAMPLES_PER_SLOT);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_PDIV = 4'd1;
    localparam logic [3:0] S_QDIV = 4'd2;
    localparam logic [3:0] S_HEAD = 4'd3;
    localparam logic [3:0] S_RD   = 4'd4;
    localparam logic [3:0] S_EDIV = 4'd5;
    localparam logic [3:0] S_CMP  = 4'd6;
    localparam logic [3:0] S_IDX  = 4'd7;
    localparam logic [3:0] S_ADDR = 4'd8;
    localparam logic [3:0] S_SRD  = 4'd9;
    localparam logic [3:0] S_SDAT = 4'd10;
    localparam logic [3:0] S_EMIT = 4'd11;

    logic [3:0]        r_state, n_state;
    logic [PER_W-1:0]  r_period, n_period;
    logic [SW-1:0]     r_head, n_head;
    logic [CW-1:0]     r_count, n_count;
    logic [TIME_W-1:0] r_t, n_t;
    logic [TIME_W-1:0] r_pt, n_pt;
    logic [TIME_W-1:0] r_pe, n_pe;
    logic [TIME_W-1:0] r_plast, n_plast;
    logic [TIME_W-1:0] r_pmt, n_pmt;
    logic [TIME_W-1:0] r_idx, n_idx;
    logic              r_last, n_last;
    logic [AW-1:0]     r_saddr, n_saddr;
    logic [BYTE_W-1:0] r_res_i, n_res_i;
    logic [BYTE_W-1:0] r_res_q, n_res_q;
    logic              r_res_miss, n_res_miss;
    logic              r_res_drop, n_res_drop;
    logic              r_out_valid, n_out_valid;
    logic [BYTE_W-1:0] r_out_i, n_out_i;
    logic [BYTE_W-1:0] r_out_q, n_out_q;
    logic              r_out_miss, n_out_miss;
    logic              r_out_drop, n_out_drop;
    logic [HELD_W-1:0] r_out_held, n_out_held;

    logic [TIME_W-1:0] per;
    logic [TIME_W-1:0] half;
    logic [SW:0]       tail_sum;
    logic [SW-1:0]     tail;
    logic [SW-1:0]     head_inc;
    logic              full;
    logic              acc;
    logic              off_ok;
    logic              is_commit;
    logic              s_we;
    logic [AW-1:0]     s_waddr;
    logic [15:0]       s_rdata;
    logic              t_we;
    logic [TIME_W-1:0] t_rdata;
    logic              div_start;
    logic [TIME_W-1:0] div_dividend;
    logic              div_done;
    logic [PER_W-1:0]  div_rem;
    logic [TIME_W-1:0] pe_raw;
    logic              early;
    logic              in_win;

    assign per  = {1'b0, r_period};
    assign half = per >> 1;

    assign tail_sum = (SW+1)'(r_head) + (SW+1)'(r_count);
    assign tail     = (tail_sum >= (SW+1)'(SLOT_COUNT)) ?
                      SW'(tail_sum - (SW+1)'(SLOT_COUNT)) : tail_sum[SW-1:0];
    assign head_inc = (r_head == SW'(SLOT_COUNT - 1)) ? '0 : r_head + 1'b1;
    assign full     = (r_count == CW'(SLOT_COUNT));

    assign i_req.ready = (r_state == S_IDLE);
    assign acc         = i_req.valid && i_req.ready;
    assign off_ok      = (TIME_W'(i_req.sample_offset) < SPS_T);
    assign is_commit   = (TIME_W'(i_req.sample_offset) == SPS_T - 1'b1);

    // Push samples are written in the accept cycle; of the pushes, only a packet commit needs the modulo unit.
    assign s_we    = acc && (i_req.opcode == OP_PUSH) && off_ok && !full;
    assign s_waddr = AW'(tail) * AW'(SAMPLES_PER_SLOT) + AW'(i_req.sample_offset);
    assign t_we    = (r_state == S_PDIV) && div_done;

    assign pe_raw = t_rdata + SPS_T;
    assign early  = time_before(r_t, r_pt, half);
    assign in_win = time_before(r_t, r_pe, half);

    always_comb begin
        div_start    = 1'b0;
        div_dividend = i_req.packet_time;
        if (r_state == S_RD) begin
            div_dividend = pe_raw;
            div_start    = (pe_raw >= (per << 1));
        end else if (acc) begin
            if (i_req.opcode == OP_PULL) begin
                div_dividend = i_req.pull_time;
                div_start    = 1'b1;
            end else begin
                div_start = off_ok && is_commit && !full;
            end
        end
    end

    tsab_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_sample_ram (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata ({i_req.q_in, i_req.i_in}),
        .i_raddr (r_saddr),
        .o_rdata (s_rdata)
    );

    tsab_ram #(.WIDTH(TIME_W), .DEPTH(SLOT_COUNT)) u_time_ram (
        .i_clk   (i_clk),
        .i_we    (t_we),
        .i_waddr (tail),
        .i_wdata ({1'b0, div_rem}),
        .i_raddr (r_head),
        .o_rdata (t_rdata)
    );

    tsab_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (r_period),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    always_comb begin
        n_state     = r_state;
        n_period    = r_period;
        n_head      = r_head;
        n_count     = r_count;
        n_t         = r_t;
        n_pt        = r_pt;
        n_pe        = r_pe;
        n_plast     = r_plast;
        n_pmt       = r_pmt;
        n_idx       = r_idx;
        n_last      = r_last;
        n_saddr     = r_saddr;
        n_res_i     = r_res_i;
        n_res_q     = r_res_q;
        n_res_miss  = r_res_miss;
        n_res_drop  = r_res_drop;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out_i     = r_out_i;
        n_out_q     = r_out_q;
        n_out_miss  = r_out_miss;
        n_out_drop  = r_out_drop;
        n_out_held  = r_out_held;

        // The stored period is already raised to its floor.
        if (i_cfg_we) begin
            n_period = (i_cfg_wdata < MIN_PER) ? MIN_PER : i_cfg_wdata;
        end

        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_res_i    = '0;
                    n_res_q    = '0;
                    n_res_miss = 1'b0;
                    n_res_drop = 1'b0;
                    if (i_req.opcode == OP_PULL) begin
                        n_state = S_QDIV;
                    end else begin
                        n_res_drop = off_ok && is_commit && full;
                        n_state    = (off_ok && is_commit && !full) ? S_PDIV : S_EMIT;
                    end
                end
            end
            S_PDIV: begin
                if (div_done) begin
                    n_count = r_count + 1'b1;
                    n_state = S_EMIT;
                end
            end
            S_QDIV: begin
                if (div_done) begin
                    n_t     = {1'b0, div_rem};
                    n_state = S_HEAD;
                end
            end
            S_HEAD: begin
                if (r_count == '0) begin
                    n_res_miss = 1'b1;
                    n_state    = S_EMIT;
                end else begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_pt  = t_rdata;
                n_pmt = per - t_rdata;
                if (pe_raw < per) begin
                    n_pe    = pe_raw;
                    n_state = S_CMP;
                end else if (pe_raw < (per << 1)) begin
                    n_pe    = pe_raw - per;
                    n_state = S_CMP;
                end else begin
                    // Start time stored under a larger period: full reduction needed.
                    n_state = S_EDIV;
                end
            end
            S_EDIV: begin
                if (div_done) begin
                    n_pe    = {1'b0, div_rem};
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_plast = (r_pe == '0) ? per - 1'b1 : r_pe - 1'b1;
                if (early) begin
                    n_res_miss = 1'b1;
                    n_state    = S_EMIT;
                end else if (in_win) begin
                    n_state = S_IDX;
                end else begin
                    n_head  = head_inc;
                    n_count = r_count - 1'b1;
                    n_state = S_HEAD;
                end
            end
            S_IDX: begin
                n_idx   = (r_t >= r_pt) ? r_t - r_pt : r_t + r_pmt;
                n_last  = (r_t == r_plast);
                n_state = S_ADDR;
            end
            S_ADDR: begin
                // The address is formed from the head slot before any pop.
                n_saddr = AW'(r_head) * AW'(SAMPLES_PER_SLOT) + AW'(r_idx);
                if (r_last) begin
                    n_head  = head_inc;
                    n_count = r_count - 1'b1;
                end
                if (r_idx < SPS_T) begin
                    n_state = S_SRD;
                end else begin
                    n_res_miss = 1'b1;
                    n_state    = S_EMIT;
                end
            end
            S_SRD: begin
                n_state = S_SDAT;
            end
            S_SDAT: begin
                n_res_i = s_rdata[BYTE_W-1:0];
                n_res_q = s_rdata[2*BYTE_W-1:BYTE_W];
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_out_i     = r_res_i;
                    n_out_q     = r_res_q;
                    n_out_miss  = r_res_miss;
                    n_out_drop  = r_res_drop;
                    n_out_held  = HELD_W'(r_count);
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_period    <= PER_RESET;
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_period    <= n_period;
            r_head      <= n_head;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_t        <= n_t;
        r_pt       <= n_pt;
        r_pe       <= n_pe;
        r_plast    <= n_plast;
        r_pmt      <= n_pmt;
        r_idx      <= n_idx;
        r_last     <= n_last;
        r_saddr    <= n_saddr;
        r_res_i    <= n_res_i;
        r_res_q    <= n_res_q;
        r_res_miss <= n_res_miss;
        r_res_drop <= n_res_drop;
        r_out_i    <= n_out_i;
        r_out_q    <= n_out_q;
        r_out_miss <= n_out_miss;
        r_out_drop <= n_out_drop;
        r_out_held <= n_out_held;
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.i_out          = r_out_i;
    assign o_rsp.q_out          = r_out_q;
    assign o_rsp.sample_missing = r_out_miss;
    assign o_rsp.push_dropped   = r_out_drop;
    assign o_rsp.packets_held   = r_out_held;

endmodule
